// ----- rtl/utf8r_pkg.sv -----
// utf8r_pkg: constants, types and helpers for the utf-8 decoder with repair
// no dependencies; imported by the decoder top level and its checker

package utf8r_pkg;

    localparam int CODE_W   = 21;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int FIFO_D   = 4;
    localparam int PTR_W    = $clog2(FIFO_D);
    localparam int CNT_W    = $clog2(FIFO_D + 1);

    // register map, byte address is 4 * index
    localparam logic [ADDR_W-1:0] REG_UTF16_OUTPUT = 3'h0;

    localparam logic [CODE_W-1:0] REPLACEMENT  = 21'h00FFFD;
    localparam logic [CODE_W-1:0] HI_SURR_BASE = 21'h00D800;
    localparam logic [CODE_W-1:0] LO_SURR_BASE = 21'h00DC00;
    localparam logic [CODE_W-1:0] HI_SURR_LAST = 21'h00DBFF;
    localparam logic [CODE_W-1:0] LO_SURR_LAST = 21'h00DFFF;
    localparam logic [CODE_W-1:0] CODE_MAX     = 21'h10FFFF;

    localparam logic [7:0] LOW_DEFAULT  = 8'h80;
    localparam logic [7:0] HIGH_DEFAULT = 8'hBF;
    localparam logic [7:0] LOW_AFTER_E0 = 8'hA0;
    localparam logic [7:0] HIGH_AFTER_ED = 8'h9F;
    localparam logic [7:0] LOW_AFTER_F0 = 8'h90;
    localparam logic [7:0] HIGH_AFTER_F4 = 8'h8F;

    // one result unit as it sits in the output queue
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              rep;
        logic              last;
    } t_unit;

    // up to two results caused by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        t_unit      u1;
        t_unit      u0;
    } t_pair;

    function automatic t_pair pair_push(t_pair p, logic [CODE_W-1:0] code, logic rep);
        t_pair q;
        q = p;
        if (p.cnt == 2'd0) begin
            q.u0.code = code;
            q.u0.rep  = rep;
            q.cnt     = 2'd1;
        end else if (p.cnt == 2'd1) begin
            q.u1.code = code;
            q.u1.rep  = rep;
            q.cnt     = 2'd2;
        end
        return q;
    endfunction

    function automatic logic is_high_surr(logic [CODE_W-1:0] c);
        return (c >= HI_SURR_BASE) && (c <= HI_SURR_LAST);
    endfunction

    function automatic logic is_low_surr(logic [CODE_W-1:0] c);
        return (c >= LO_SURR_BASE) && (c <= LO_SURR_LAST);
    endfunction

endpackage

// ----- rtl/utf8_decoder_with_repair.sv -----
// utf8_decoder_with_repair: validating utf-8 to utf-32 / utf-16 decoder
// depends on utf8r_pkg (constants, t_unit, t_pair, pair_push)
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+-------------------------------------
//  input    | i_in_valid / o_in_stall           | i_in_byte, i_in_string_end
//  output   | o_out_valid / i_out_stall         | o_code_unit, o_was_replaced, o_run_last
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// one byte is taken per cycle unless o_in_stall is high; the decode of that byte
// and the state update happen in the same cycle and its 0..2 result units land
// in a 4-entry queue. the queue drains one unit per cycle while i_out_stall is low,
// so the rate is one byte per cycle as long as the stream averages at most one unit
// per byte; a surrogate pair or a replacement followed by another unit is two units.
// o_in_stall is high while fewer than two queue slots are free (registered).
// synchronous active-low reset clears the decoder state, the mode and the queue.

module utf8_decoder_with_repair
    import utf8r_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // byte input transaction
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_string_end,

    // result output transaction
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CODE_W-1:0]     o_code_unit,
    output logic                  o_was_replaced,
    output logic                  o_run_last,

    // apb-style config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    // decoder state
    logic [CODE_W-1:0] r_partial, n_partial;
    logic [1:0]        r_needed,  n_needed;
    logic [1:0]        r_seen,    n_seen;
    logic [7:0]        r_low,     n_low;
    logic [7:0]        r_high,    n_high;
    logic              r_utf16;

    // output queue
    t_unit             r_fifo [FIFO_D];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic              w_in_accept;
    logic              w_out_accept;
    logic              w_cfg_write;

    logic              w_active;
    logic              w_bad_cont;
    logic              w_good_cont;
    logic              w_complete;
    logic [1:0]        w_seen_inc;
    logic [CODE_W-1:0] w_cont_code;
    logic [19:0]       w_supp_off;
    t_pair             w_pair;

    assign pready       = 1'b1;
    assign w_cfg_write  = psel && penable && pwrite && pready;
    assign prdata       = (paddr == REG_UTF16_OUTPUT) ? {{(DATA_W-1){1'b0}}, r_utf16}
                                                      : '0;

    // two free slots are needed since one byte can cause two units
    assign o_in_stall   = (r_count > CNT_W'(FIFO_D - 2));
    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign o_out_valid  = (r_count != '0);
    assign w_out_accept = o_out_valid && !i_out_stall;

    assign o_code_unit    = r_fifo[r_rd_ptr].code;
    assign o_was_replaced = r_fifo[r_rd_ptr].rep;
    assign o_run_last     = r_fifo[r_rd_ptr].last;

    // continuation checks against the current window
    assign w_active    = (r_needed != 2'd0);
    assign w_bad_cont  = w_active && ((i_in_byte < r_low) || (i_in_byte > r_high));
    assign w_good_cont = w_active && !w_bad_cont;
    assign w_seen_inc  = r_seen + 2'd1;
    assign w_complete  = w_good_cont && (w_seen_inc >= r_needed);
    assign w_cont_code = {r_partial[CODE_W-7:0], i_in_byte[5:0]};
    // offset above the basic plane for surrogate pairs
    assign w_supp_off  = 20'(w_cont_code - 21'h010000);

    always_comb begin
        n_partial = r_partial;
        n_needed  = r_needed;
        n_seen    = r_seen;
        n_low     = r_low;
        n_high    = r_high;
        w_pair    = '0;

        if (w_good_cont) begin
            n_low     = LOW_DEFAULT;
            n_high    = HIGH_DEFAULT;
            n_partial = w_cont_code;
            n_seen    = w_seen_inc;
            if (w_complete) begin
                n_partial = '0;
                n_needed  = 2'd0;
                n_seen    = 2'd0;
                if (r_utf16 && (w_cont_code[CODE_W-1:16] != '0)) begin
                    // supplementary code point -> high then low surrogate
                    w_pair = pair_push(w_pair,
                                       HI_SURR_BASE + CODE_W'(w_supp_off[19:10]), 1'b0);
                    w_pair = pair_push(w_pair,
                                       LO_SURR_BASE + CODE_W'(w_supp_off[9:0]), 1'b0);
                end else begin
                    w_pair = pair_push(w_pair, w_cont_code, 1'b0);
                end
            end
        end else begin
            // no open sequence, or a broken one: restart and treat as a lead
            n_partial = '0;
            n_needed  = 2'd0;
            n_seen    = 2'd0;
            n_low     = LOW_DEFAULT;
            n_high    = HIGH_DEFAULT;
            if (w_bad_cont) begin
                w_pair = pair_push(w_pair, REPLACEMENT, 1'b1);
            end
            if (i_in_byte inside {[8'h00:8'h7F]}) begin
                w_pair = pair_push(w_pair, CODE_W'(i_in_byte), 1'b0);
            end else if (i_in_byte inside {[8'hC2:8'hDF]}) begin
                n_partial = CODE_W'(i_in_byte[4:0]);
                n_needed  = 2'd1;
            end else if (i_in_byte inside {[8'hE0:8'hEF]}) begin
                n_partial = CODE_W'(i_in_byte[3:0]);
                n_needed  = 2'd2;
                if (i_in_byte == 8'hE0) begin
                    n_low = LOW_AFTER_E0;
                end else if (i_in_byte == 8'hED) begin
                    n_high = HIGH_AFTER_ED;
                end
            end else if (i_in_byte inside {[8'hF0:8'hF4]}) begin
                n_partial = CODE_W'(i_in_byte[2:0]);
                n_needed  = 2'd3;
                if (i_in_byte == 8'hF0) begin
                    n_low = LOW_AFTER_F0;
                end else if (i_in_byte == 8'hF4) begin
                    n_high = HIGH_AFTER_F4;
                end
            end else begin
                // stray continuation, overlong c0/c1, or f5 and above
                w_pair = pair_push(w_pair, REPLACEMENT, 1'b1);
            end
        end

        // end of string flushes a sequence left open
        if (i_in_string_end) begin
            if (n_needed != 2'd0) begin
                w_pair = pair_push(w_pair, REPLACEMENT, 1'b1);
            end
            n_partial = '0;
            n_needed  = 2'd0;
            n_seen    = 2'd0;
            n_low     = LOW_DEFAULT;
            n_high    = HIGH_DEFAULT;
        end

        w_pair.u0.last = (w_pair.cnt == 2'd1);
        w_pair.u1.last = 1'b1;
    end

    // decoder state and mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_needed  <= 2'd0;
            r_seen    <= 2'd0;
            r_low     <= LOW_DEFAULT;
            r_high    <= HIGH_DEFAULT;
            r_utf16   <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_partial <= n_partial;
                r_needed  <= n_needed;
                r_seen    <= n_seen;
                r_low     <= n_low;
                r_high    <= n_high;
            end
            if (w_cfg_write && (paddr == REG_UTF16_OUTPUT)) begin
                r_utf16 <= pwdata[0];
            end
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept && (w_pair.cnt != 2'd0)) begin
            r_fifo[r_wr_ptr] <= w_pair.u0;
        end
        if (w_in_accept && (w_pair.cnt == 2'd2)) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= w_pair.u1;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_in_accept) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(w_pair.cnt);
            end
            if (w_out_accept) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count
                     + (w_in_accept ? CNT_W'(w_pair.cnt) : CNT_W'(0))
                     - (w_out_accept ? CNT_W'(1) : CNT_W'(0));
        end
    end

endmodule

// ----- rtl/utf8r_checker.sv -----
// utf8r_checker: port-level assertions for utf8_decoder_with_repair
// depends on utf8r_pkg; attached to the top level by the bind at the end

module utf8r_checker
    import utf8r_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic [CODE_W-1:0]     o_code_unit,
    input  logic                  o_was_replaced,
    input  logic                  o_run_last
);

    // a replacement unit always carries u+fffd
    a_rep_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_replaced) |-> (o_code_unit == REPLACEMENT))
        else $error("replacement unit is not u+fffd");

    // a high surrogate is never the last unit of its byte
    a_high_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && is_high_surr(o_code_unit)) |-> !o_run_last)
        else $error("high surrogate marked as last unit");

    // a low surrogate always closes its byte and is never a replacement
    a_low_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && is_low_surr(o_code_unit)) |-> (o_run_last && !o_was_replaced))
        else $error("low surrogate not last or flagged replaced");

    // stalled output holds its unit
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_code_unit) && $stable(o_was_replaced)
             && $stable(o_run_last)))
        else $error("output changed while stalled");

    // no unit beyond the unicode range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_code_unit <= CODE_MAX))
        else $error("code unit above u+10ffff");

endmodule

bind utf8_decoder_with_repair utf8r_checker u_utf8r_checker (.*);

// ----- dv/tb_utf8_decoder_with_repair.sv -----
// tb_utf8_decoder_with_repair: self-checking testbench for the utf-8 decoder with repair
// depends on utf8r_pkg and utf8_decoder_with_repair; predicts every result unit in-line

module tb_utf8_decoder_with_repair;
    import utf8r_pkg::*;

    // byte classes of the utf-8 lead byte
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD_2B_MIN  = 8'hC2;
    localparam logic [7:0] LEAD_3B_MIN  = 8'hE0;
    localparam logic [7:0] LEAD_ED      = 8'hED;
    localparam logic [7:0] LEAD_4B_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_F4      = 8'hF4;
    localparam logic [7:0] LEAD_END     = 8'hF5;
    localparam logic [CODE_W-1:0] SUPPLEMENTARY_BASE = 21'h010000;

    // index 1 in the register map, which does not exist
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 3'h4;

    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 30;
    localparam int QUIET_LIMIT   = 3000;
    localparam int LONG_HOLD     = 100;
    localparam int REPORT_CAP    = 100;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } t_feed_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_in_byte = 8'h00;
    logic              i_in_string_end = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [CODE_W-1:0] o_code_unit;
    logic              o_was_replaced;
    logic              o_run_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    utf8_decoder_with_repair u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_in_string_end (i_in_string_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_code_unit     (o_code_unit),
        .o_was_replaced  (o_was_replaced),
        .o_run_last      (o_run_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // decoder prediction: own copy of the sequence state and the mode
    // ------------------------------------------------------------------
    logic [CODE_W-1:0] acc_code   = '0;
    logic [1:0]        need_cnt   = 2'd0;
    logic [1:0]        seen_cnt   = 2'd0;
    logic [7:0]        lim_lo     = LOW_DEFAULT;
    logic [7:0]        lim_hi     = HIGH_DEFAULT;
    logic              mode_utf16 = 1'b0;

    t_unit      step_units[$];     // units caused by the byte being decoded
    t_unit      pending_units[$];  // units still owed by the block, oldest first
    t_feed_item byte_feed[$];      // bytes waiting for the driver

    int mismatches = 0;

    function automatic void clear_seq();
        acc_code = '0;
        need_cnt = 2'd0;
        seen_cnt = 2'd0;
        lim_lo   = LOW_DEFAULT;
        lim_hi   = HIGH_DEFAULT;
    endfunction

    function automatic void emit_unit(logic [CODE_W-1:0] code, logic rep);
        // at most two units per byte, later ones are dropped
        if (step_units.size() < 2)
            step_units.insert(step_units.size(), t_unit'{code: code, rep: rep, last: 1'b0});
    endfunction

    function automatic void emit_char(logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] off;
        if (mode_utf16 && code >= SUPPLEMENTARY_BASE) begin
            off = code - SUPPLEMENTARY_BASE;
            emit_unit(HI_SURR_BASE + CODE_W'(off[19:10]), 1'b0);
            emit_unit(LO_SURR_BASE + CODE_W'(off[9:0]), 1'b0);
        end else begin
            emit_unit(code, 1'b0);
        end
    endfunction

    // byte seen with no sequence open
    function automatic void open_or_emit(logic [7:0] b);
        if (b < ASCII_LIMIT) begin
            emit_char({13'b0, b});
        end else if (b < LEAD_2B_MIN) begin
            emit_unit(REPLACEMENT, 1'b1);
        end else if (b < LEAD_3B_MIN) begin
            acc_code = {16'b0, b[4:0]};
            need_cnt = 2'd1;
        end else if (b < LEAD_4B_MIN) begin
            acc_code = {17'b0, b[3:0]};
            if (b == LEAD_3B_MIN)
                lim_lo = LOW_AFTER_E0;
            else if (b == LEAD_ED)
                lim_hi = HIGH_AFTER_ED;
            need_cnt = 2'd2;
        end else if (b < LEAD_END) begin
            acc_code = {18'b0, b[2:0]};
            if (b == LEAD_4B_MIN)
                lim_lo = LOW_AFTER_F0;
            else if (b == LEAD_F4)
                lim_hi = HIGH_AFTER_F4;
            need_cnt = 2'd3;
        end else begin
            emit_unit(REPLACEMENT, 1'b1);
        end
    endfunction

    // one accepted byte transaction -> 0..2 expected units
    function automatic void decode_byte(logic [7:0] b, logic eos);
        logic [CODE_W-1:0] done_code;
        t_unit             u;
        step_units.delete();
        if (need_cnt == 2'd0) begin
            open_or_emit(b);
        end else if (b < lim_lo || b > lim_hi) begin
            // bad continuation: replace, then retry the same byte as a lead
            clear_seq();
            emit_unit(REPLACEMENT, 1'b1);
            open_or_emit(b);
        end else begin
            lim_lo   = LOW_DEFAULT;
            lim_hi   = HIGH_DEFAULT;
            acc_code = {acc_code[14:0], b[5:0]};
            seen_cnt = seen_cnt + 2'd1;
            if (seen_cnt >= need_cnt) begin
                done_code = acc_code;
                clear_seq();
                emit_char(done_code);
            end
        end
        // string end flushes an open sequence with one more replacement
        if (eos) begin
            if (need_cnt != 2'd0)
                emit_unit(REPLACEMENT, 1'b1);
            clear_seq();
        end
        foreach (step_units[k]) begin
            u = step_units[k];
            u.last = (k == step_units.size() - 1);
            pending_units.insert(pending_units.size(), u);
        end
    endfunction

    function automatic void report_mismatch(string what, logic [DATA_W-1:0] want,
                                            logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    // gap lengths: mostly none or short, now and then long
    function automatic int pick_gap(bit en);
        int r;
        if (!en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // byte driver: offers queued bytes, predicts each accepted transaction
    // ------------------------------------------------------------------
    bit in_idle_en  = 1'b0;
    bit out_idle_en = 1'b0;
    int in_gap      = 0;

    always @(posedge i_clk) begin
        t_feed_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                decode_byte(i_in_byte, i_in_string_end);
            // payload only moves once the current byte is gone
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (byte_feed.size() != 0) begin
                    nxt = byte_feed.pop_front();
                    i_in_valid      <= 1'b1;
                    i_in_byte       <= nxt.data;
                    i_in_string_end <= nxt.eos;
                    in_gap = pick_gap(in_idle_en);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output stall: random back-pressure plus requested long hold-offs
    // ------------------------------------------------------------------
    int hold_req   = 0;   // bumped by the stimulus at a negedge
    int holds_done = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (hold_req != holds_done) begin
            // long hold so the output queue fills and the input stalls
            holds_done++;
            stall_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            n = (out_idle_en && $urandom_range(0, 2) == 0) ? pick_gap(1'b1) : 0;
            stall_left = (n > 0) ? n - 1 : 0;
            i_out_stall <= (n > 0);
        end
    end

    // ------------------------------------------------------------------
    // monitor: every accepted unit against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_unit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_units.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected unit, expected none, actual code %h rep %b last %b",
                         $time, o_code_unit, o_was_replaced, o_run_last);
            end else begin
                want = pending_units.pop_front();
                if (o_code_unit !== want.code)
                    report_mismatch("code_unit", DATA_W'(want.code), DATA_W'(o_code_unit));
                if (o_was_replaced !== want.rep)
                    report_mismatch("was_replaced", DATA_W'(want.rep),
                                    DATA_W'(o_was_replaced));
                if (o_run_last !== want.last)
                    report_mismatch("run_last", DATA_W'(want.last), DATA_W'(o_run_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction on any port
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("utf8_decoder_with_repair test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // config port: setup cycle, then access cycle until pready
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // writes to anything but the mode register are dropped
        if (addr == REG_UTF16_OUTPUT)
            mode_utf16 = value[0];
    endtask

    task automatic check_mode_reg();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_UTF16_OUTPUT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(DATA_W-1){1'b0}}, mode_utf16})
            report_mismatch("utf16_output readback", {{(DATA_W-1){1'b0}}, mode_utf16},
                            prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mode(input bit utf16);
        logic [DATA_W-1:0] value;
        value = $urandom();
        value[0] = utf16;
        cfg_write(REG_UTF16_OUTPUT, value);
        check_mode_reg();
    endtask

    // wait for the driver to empty, every unit to arrive, then a short settle
    task automatic wait_idle(input int settle);
        do @(negedge i_clk);
        while (byte_feed.size() != 0 || i_in_valid || pending_units.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] data, logic eos);
        byte_feed.insert(byte_feed.size(), t_feed_item'{data: data, eos: eos});
    endfunction

    // one well-formed character of random length and content
    function automatic void push_char(logic eos);
        logic [20:0] cp;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            cp = 21'($urandom_range(0, 'h7F));
            push_byte(cp[7:0], eos);
        end else if (r < 55) begin
            cp = 21'($urandom_range('h80, 'h7FF));
            push_byte({3'b110, cp[10:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, eos);
        end else if (r < 80) begin
            do cp = 21'($urandom_range('h800, 'hFFFF));
            while (cp >= HI_SURR_BASE && cp <= LO_SURR_LAST);
            push_byte({4'b1110, cp[15:12]}, 1'b0);
            push_byte({2'b10, cp[11:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, eos);
        end else begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
            push_byte({5'b11110, cp[20:18]}, 1'b0);
            push_byte({2'b10, cp[17:12]}, 1'b0);
            push_byte({2'b10, cp[11:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, eos);
        end
    endfunction

    // byte near a limit of some continuation range or a lead class, or a random byte
    function automatic logic [7:0] edge_byte();
        logic [7:0] picks[14] = '{8'h00, 8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0,
                                  8'hBF, 8'hC0, 8'hC2, 8'hE0, 8'hF4, 8'hF5, 8'hFF};
        return ($urandom_range(0, 1) == 0) ? picks[$urandom_range(0, 13)]
                                           : 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_random(int count);
        int start;
        int r;
        int n;
        start = byte_feed.size();
        while (byte_feed.size() - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                push_char($urandom_range(0, 11) == 0);
            end else if (r < 90) begin
                // lead followed by a possibly bad or short tail
                push_byte(8'($urandom_range(LEAD_2B_MIN, LEAD_F4)), $urandom_range(0, 9) == 0);
                n = $urandom_range(0, 2);
                repeat (n)
                    push_byte(edge_byte(), $urandom_range(0, 5) == 0);
            end else begin
                n = $urandom_range(1, 3);
                repeat (n)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end
        end
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_mode_reg();

        // directed, utf-32 out: single bytes, bad leads, short sequences
        @(negedge i_clk);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hC1, 1'b0);
        push_byte(8'hF5, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hC2, 1'b0);               // smallest two-byte code
        push_byte(8'h80, 1'b0);
        push_byte(8'hE0, 1'b0);               // overlong, second byte also a bad lead
        push_byte(8'h9F, 1'b0);
        push_byte(8'hC2, 1'b0);               // ascii cuts the sequence short
        push_byte(8'h41, 1'b0);
        push_byte(8'hED, 1'b0);               // surrogate range is refused
        push_byte(8'hA0, 1'b0);
        push_byte(8'hE1, 1'b0);               // string ends with a sequence open
        push_byte(8'h80, 1'b1);
        push_byte(8'hF0, 1'b0);               // left open across the mode change
        wait_idle(SETTLE_CYCLES);

        // directed, utf-16 out: finish the open sequence as a surrogate pair
        set_mode(1'b1);
        @(negedge i_clk);
        push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hEF, 1'b0);               // real u+fffd, not a replacement
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBD, 1'b0);
        push_byte(8'hF4, 1'b0);               // highest code point
        push_byte(8'h8F, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        wait_idle(SETTLE_CYCLES);

        // write to an unmapped register must leave the mode alone
        cfg_write(UNMAPPED_ADDR, '0);
        check_mode_reg();

        // random phases, alternating modes and idling patterns
        for (int phase = 0; phase < 6; phase++) begin
            set_mode(phase[0]);
            @(negedge i_clk);
            in_idle_en  = (phase != 2) && (phase != 4);
            out_idle_en = (phase != 3) && (phase != 4);
            push_random(142);
            if (phase == 1 || phase == 4)
                hold_req++;
            wait_idle(SETTLE_CYCLES);
        end

        wait_idle(END_CYCLES);
        if (mismatches == 0)
            $display("utf8_decoder_with_repair test passed");
        else
            $display("utf8_decoder_with_repair test failed");
        $finish;
    end

endmodule
